FILE: rtl/core/tcg_pkg.sv
// package: constants, types and helpers of the tone and chirp test-signal generator
`timescale 1ns / 1ps

package tcg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int INDEX_BITS      = 16;
  localparam int CMP_W           = (INDEX_BITS > 16) ? INDEX_BITS : 16;

  localparam int OP_A_W = 31;
  localparam int OP_B_W = 17;
  localparam int PROD_W = OP_A_W + OP_B_W;

  localparam logic [15:0] POLY_A    = 16'd51472;
  localparam logic [15:0] POLY_B    = 16'd21167;
  localparam logic [15:0] POLY_C    = 16'd2463;
  localparam logic [18:0] ENV_UNIT  = 19'd32768;
  localparam logic [29:0] UNIT_Q29  = 30'h2000_0000;

  localparam logic [1:0]  RST_MODE       = 2'd2;
  localparam logic [15:0] RST_AMPLITUDE  = 16'd9830;
  localparam logic [14:0] RST_FULL_SCALE = 15'd4500;
  localparam logic [15:0] RST_LENGTH     = 16'd16000;
  localparam logic [11:0] RST_FADE_LEN   = 12'd80;
  localparam logic [30:0] RST_FADE_STEP  = 31'd13421773;

  typedef enum logic [1:0] {
    MODE_TONE    = 2'd0,
    MODE_CHIRP   = 2'd1,
    MODE_SILENCE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_STEP_START = 3'd1,
    REG_STEP_DELTA = 3'd2,
    REG_AMPLITUDE  = 3'd3,
    REG_FULL_SCALE = 3'd4,
    REG_LENGTH     = 3'd5,
    REG_FADE_LEN   = 3'd6,
    REG_FADE_STEP  = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EPHASE,
    ST_SX2,
    ST_ST1,
    ST_ST2,
    ST_SM,
    ST_ENV,
    ST_AMP,
    ST_VAL,
    ST_SCALE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        neg;
    logic [15:0] x;
  } sine_in_t;

  // quarter-wave position and sign of a 32-bit phase
  function automatic sine_in_t sine_in(input logic [31:0] ph);
    logic [SINE_TABLE_BITS-1:0] k;
    logic [14:0]                x15;
    sine_in_t                   r;
    k     = ph[31 -: SINE_TABLE_BITS];
    x15   = 15'(k[SINE_TABLE_BITS-3:0]) << (17 - SINE_TABLE_BITS);
    r.neg = k[SINE_TABLE_BITS-1];
    r.x   = k[SINE_TABLE_BITS-2] ? (16'd32768 - {1'b0, x15}) : {1'b0, x15};
    return r;
  endfunction

endpackage

FILE: rtl/core/tone_chirp_test_signal_generator.sv
// top level: tone and linear chirp test-signal generator with raised-cosine fade
`timescale 1ns / 1ps

// One restart word in gives one signed 16-bit sample word out. All multiplies run
// through a single 31x17 multiplier under a small sequencer, one multiply per cycle,
// so the block takes one word at a time and is not ready while it works. After the
// accept a check state sends a finished signal or silence straight to the output
// state; a tone sample first runs square, two polynomial steps, sine, amplitude,
// value and scale, and a chirp sample inside a fade window runs envelope phase, sine
// and square before the main sine. The output state waits while a sample is held
// unaccepted; the output register lets the next word be taken while a sample waits.
// Registers are read live and must only be written while the block is idle.
module tone_chirp_test_signal_generator
  import tcg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  output logic               last_o
);

  // configuration
  logic [1:0]  mode_q;
  logic [30:0] step_start_q;
  logic [20:0] step_delta_q;
  logic [15:0] amplitude_q;
  logic [14:0] full_scale_q;
  logic [15:0] length_q;
  logic [11:0] fade_len_q;
  logic [30:0] fade_step_q;

  // generator state
  logic [INDEX_BITS-1:0] idx_q;
  logic [31:0]           acc_q;
  logic [31:0]           step_q;

  state_e state_q, state_d;

  // working registers
  logic [15:0] x_q, x2_q, t_q, pos_q, res_q;
  logic [16:0] m_q;
  logic [18:0] env_q;
  logic [19:0] a_q;
  logic [29:0] mag_q;
  logic        neg_q, env_path_q, adv_q, last_res_q;

  logic               out_valid_q;
  logic signed [15:0] sample_q;
  logic               last_q;

  // shared multiplier
  logic [OP_A_W-1:0] op_a;
  logic [OP_B_W-1:0] op_b;
  logic [PROD_W-1:0] prod;

  // decisions
  logic [CMP_W-1:0] idx_ext, len_ext, fl_ext, rem_ext;
  logic             active, tone_like, fade_in, fade_out, is_last, out_free;
  sine_in_t         acc_sin, env_sin;
  logic [15:0]      scaled;

  assign idx_ext   = CMP_W'(idx_q);
  assign len_ext   = CMP_W'(length_q);
  assign fl_ext    = CMP_W'(fade_len_q);
  assign rem_ext   = len_ext - idx_ext;
  assign active    = (idx_ext < len_ext) && (idx_q != {INDEX_BITS{1'b1}});
  assign tone_like = (mode_q == MODE_TONE) || (mode_q == MODE_CHIRP);
  assign fade_in   = idx_ext < fl_ext;
  assign fade_out  = rem_ext < fl_ext;
  assign is_last   = (idx_ext + CMP_W'(1)) == len_ext;
  assign out_free  = !out_valid_q || out_ready_i;
  assign acc_sin   = sine_in(acc_q);
  assign env_sin   = sine_in(prod[31:0]);
  assign scaled    = prod[44:29];
  assign prod      = PROD_W'(op_a) * PROD_W'(op_b);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!active || !tone_like) state_d = ST_OUT;
        else if (mode_q == MODE_CHIRP && (fade_in || fade_out)) state_d = ST_EPHASE;
        else state_d = ST_SX2;
      end
      ST_EPHASE: state_d = ST_SX2;
      ST_SX2:    state_d = ST_ST1;
      ST_ST1:    state_d = ST_ST2;
      ST_ST2:    state_d = ST_SM;
      ST_SM:     state_d = env_path_q ? ST_ENV : ST_AMP;
      ST_ENV:    state_d = ST_SX2;
      ST_AMP:    state_d = ST_VAL;
      ST_VAL:    state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    op_a       = '0;
    op_b       = '0;
    unique case (state_q)
      ST_EPHASE: begin op_a = fade_step_q;        op_b = OP_B_W'(pos_q);        end
      ST_SX2:    begin op_a = OP_A_W'(x_q);       op_b = OP_B_W'(x_q);          end
      ST_ST1:    begin op_a = OP_A_W'(x2_q);      op_b = OP_B_W'(POLY_C);       end
      ST_ST2:    begin op_a = OP_A_W'(x2_q);      op_b = OP_B_W'(t_q);          end
      ST_SM:     begin op_a = OP_A_W'(x_q);       op_b = OP_B_W'(t_q);          end
      ST_ENV:    begin op_a = OP_A_W'(m_q);       op_b = m_q;                   end
      ST_AMP:    begin op_a = OP_A_W'(env_q);     op_b = OP_B_W'(amplitude_q);  end
      ST_VAL:    begin op_a = OP_A_W'(a_q);       op_b = m_q;                   end
      ST_SCALE:  begin op_a = OP_A_W'(mag_q);     op_b = OP_B_W'(full_scale_q); end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= RST_MODE;
      step_start_q <= '0;
      step_delta_q <= '0;
      amplitude_q  <= RST_AMPLITUDE;
      full_scale_q <= RST_FULL_SCALE;
      length_q     <= RST_LENGTH;
      fade_len_q   <= RST_FADE_LEN;
      fade_step_q  <= RST_FADE_STEP;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_MODE:       mode_q       <= cfg_data_i[1:0];
        REG_STEP_START: step_start_q <= cfg_data_i;
        REG_STEP_DELTA: step_delta_q <= cfg_data_i[20:0];
        REG_AMPLITUDE:  amplitude_q  <= cfg_data_i[15:0];
        REG_FULL_SCALE: full_scale_q <= cfg_data_i[14:0];
        REG_LENGTH:     length_q     <= cfg_data_i[15:0];
        REG_FADE_LEN:   fade_len_q   <= cfg_data_i[11:0];
        REG_FADE_STEP:  fade_step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      acc_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      env_path_q  <= 1'b0;
      adv_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && restart_i) begin
            idx_q  <= '0;
            acc_q  <= '0;
            step_q <= {1'b0, step_start_q};
          end
        end
        ST_CHECK: begin
          adv_q      <= active;
          env_path_q <= mode_q == MODE_CHIRP && (fade_in || fade_out);
        end
        ST_ENV: env_path_q <= 1'b0;
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (adv_q) begin
              acc_q <= acc_q + step_q;
              idx_q <= idx_q + INDEX_BITS'(1);
              if (mode_q == MODE_CHIRP) begin
                step_q <= step_q + {{11{step_delta_q[20]}}, step_delta_q};
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_CHECK: begin
        res_q      <= '0;
        last_res_q <= active && is_last;
        env_q      <= ENV_UNIT;
        pos_q      <= fade_in ? idx_ext[15:0] : rem_ext[15:0];
        x_q        <= acc_sin.x;
        neg_q      <= acc_sin.neg;
      end
      ST_EPHASE: x_q <= env_sin.x;
      ST_SX2:    x2_q <= prod[30:15];
      ST_ST1:    t_q <= POLY_B - prod[30:15];
      ST_ST2:    t_q <= POLY_A - prod[30:15];
      ST_SM:     m_q <= prod[31:15];
      ST_ENV: begin
        env_q <= prod[33:15];
        x_q   <= acc_sin.x;
        neg_q <= acc_sin.neg;
      end
      ST_AMP:    a_q <= prod[34:15];
      ST_VAL:    mag_q <= (prod > PROD_W'(UNIT_Q29)) ? UNIT_Q29 : prod[29:0];
      ST_SCALE:  res_q <= neg_q ? (16'd0 - scaled) : scaled;
      ST_OUT: begin
        if (out_free) begin
          sample_q <= res_q;
          last_q   <= last_res_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

endmodule

FILE: rtl/core/tcg_checker.sv
// port checker for the test-signal generator and its bind
`timescale 1ns / 1ps

module tcg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] sample_o,
  input logic               last_o
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // one word at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after accept");

  // a new result only comes from a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work");

  // a new word is loaded only when the block goes idle
  a_load_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o ##1 out_valid_o |-> in_ready_o)
    else $error("result loaded without returning to idle");

endmodule

bind tone_chirp_test_signal_generator tcg_checker u_tcg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .sample_o    (sample_o),
  .last_o      (last_o)
);
